// ===== src/rsnp_pkg.sv =====
// ----------------------------------------------------------------------------
// RSN element parser package
// Field widths, suite identifier constants and suite type decoders shared by
// the element parser.
// ----------------------------------------------------------------------------
package rsnp_pkg;

    localparam int BYTE_W  = 8;
    localparam int OUI_W   = 24;
    localparam int VER_W   = 2;
    localparam int LEFT_W  = 6;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 32;

    localparam logic [OUI_W-1:0] OUI_WPA = 24'h0050F2;
    localparam logic [OUI_W-1:0] OUI_RSN = 24'h000FAC;

    localparam logic [VER_W-1:0] VER_NONE = 2'd0;
    localparam logic [VER_W-1:0] VER_WPA  = 2'd1;
    localparam logic [VER_W-1:0] VER_RSN  = 2'd2;

    localparam logic [BYTE_W-1:0] CT_WEP40  = 8'd1;
    localparam logic [BYTE_W-1:0] CT_TKIP   = 8'd2;
    localparam logic [BYTE_W-1:0] CT_CCMP   = 8'd4;
    localparam logic [BYTE_W-1:0] CT_WEP104 = 8'd5;
    localparam logic [BYTE_W-1:0] AT_8021X  = 8'd1;
    localparam logic [BYTE_W-1:0] AT_PSK    = 8'd2;

    function automatic logic oui_known(input logic [OUI_W-1:0] oui);
        return (oui == OUI_WPA) || (oui == OUI_RSN);
    endfunction

    function automatic logic [VER_W-1:0] oui_version(input logic [OUI_W-1:0] oui);
        logic [VER_W-1:0] v;
        v = VER_NONE;
        if (oui == OUI_WPA)
        begin
            v = VER_WPA;
        end
        else if (oui == OUI_RSN)
        begin
            v = VER_RSN;
        end
        return v;
    endfunction

    function automatic logic [BYTE_W-1:0] cipher_bits(input logic [BYTE_W-1:0] t);
        logic [BYTE_W-1:0] m;
        case (t)
            CT_WEP40:  m = 8'h02;
            CT_TKIP:   m = 8'h04;
            CT_CCMP:   m = 8'h10;
            CT_WEP104: m = 8'h20;
            default:   m = 8'h00;
        endcase
        return m;
    endfunction

    function automatic logic [BYTE_W-1:0] akm_bits(input logic [BYTE_W-1:0] t);
        logic [BYTE_W-1:0] m;
        case (t)
            AT_8021X: m = 8'h02;
            AT_PSK:   m = 8'h04;
            default:  m = 8'h00;
        endcase
        return m;
    endfunction

endpackage

// ===== src/rsn_element_suite_parser.sv =====
// ----------------------------------------------------------------------------
// RSN element suite parser
// Parses one WPA or RSN information element, one byte per beat, into a
// version increment and group, pairwise and key management masks.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one element byte per beat together with the
// element length and the default cipher and authentication masks. The length
// must stay the same for all bytes of one element; defaults are taken from
// the first byte. The byte whose position plus one reaches the length closes
// the element and produces exactly one result beat; other bytes produce none.
// An element shorter than two bytes yields version 0 and the defaults.
// Throughput: one byte per cycle, sustained, including back-to-back elements,
// as long as no closing byte waits for a full result register. A byte is
// held in the input register, where the parser state is updated; the result
// beat is loaded as the closing byte leaves that register.
// Stall: while a result waits in the output register, non-closing bytes keep
// flowing; a second closing byte waits in the input register, and s_axis_tready
// drops only then.
// Reset clears the parser to the header position and empties both registers.
// ----------------------------------------------------------------------------
module rsn_element_suite_parser
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0], elem_len[15:8], default_cipher[23:16], default_auth[31:24]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // version_add[1:0], group_mask[9:2], pair_mask[17:10], auth_mask[25:18], zero fill
    output logic [31:0] m_axis_tdata
);

    typedef enum logic [2:0]
    {
        PH_HEADER  = 3'd0,
        PH_GROUP   = 3'd1,
        PH_PCNT_LO = 3'd2,
        PH_PCNT_HI = 3'd3,
        PH_PLIST   = 3'd4,
        PH_ACNT_LO = 3'd5,
        PH_ACNT_HI = 3'd6,
        PH_ALIST   = 3'd7
    } phase_t;

    localparam int BW = rsnp_pkg::BYTE_W;

    // input register
    logic          in_valid_reg;
    logic [BW-1:0] in_byte_reg;
    logic [BW-1:0] in_len_reg;
    logic [BW-1:0] in_dcip_reg;
    logic [BW-1:0] in_dauth_reg;

    // parser state
    logic [BW-1:0]                 pos_reg,   pos_next;
    phase_t                        phase_reg, phase_next;
    logic [rsnp_pkg::OUI_W-1:0]    suite_reg, suite_next;
    logic [BW-1:0]                 cnt_reg,   cnt_next;
    logic [rsnp_pkg::LEFT_W-1:0]   left_reg,  left_next;
    logic                          stop_reg,  stop_next;
    logic [rsnp_pkg::VER_W-1:0]    ver_reg,   ver_next;
    logic [BW-1:0]                 grp_reg,   grp_next;
    logic [BW-1:0]                 pair_reg,  pair_next;
    logic [BW-1:0]                 auth_reg,  auth_next;
    logic [BW-1:0]                 dcip_reg,  dcip_next;
    logic [BW-1:0]                 dauth_reg, dauth_next;

    // result register
    logic                          res_valid_reg;
    logic [rsnp_pkg::VER_W-1:0]    res_ver_reg;
    logic [BW-1:0]                 res_grp_reg;
    logic [BW-1:0]                 res_pair_reg;
    logic [BW-1:0]                 res_auth_reg;

    logic [rsnp_pkg::VER_W-1:0]    fin_ver;
    logic [BW-1:0]                 fin_grp;
    logic [BW-1:0]                 fin_pair;
    logic [BW-1:0]                 fin_auth;

    logic          is_last;
    logic          advance;
    logic          in_take;
    logic [BW-1:0] avail;
    logic          too_long;
    logic [1:0]    offset;
    logic          akm;

    // Only a closing byte needs room in the result register.
    assign is_last       = ({1'b0, pos_reg} + 9'd1) >= {1'b0, in_len_reg};
    assign advance       = in_valid_reg && (!is_last || !res_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // Bytes left after the count byte; a list longer than this stops the parse.
    assign avail    = (in_len_reg > pos_reg) ? (in_len_reg - pos_reg - 8'd1) : '0;
    assign too_long = (in_byte_reg != '0) || ({cnt_reg, 2'b00} > {2'b00, avail});
    assign akm      = (phase_reg == PH_ALIST);
    assign offset   = akm ? (pos_reg[1:0] + 2'd2) : pos_reg[1:0];

    always_comb
    begin
        phase_next = phase_reg;
        suite_next = suite_reg;
        cnt_next   = cnt_reg;
        left_next  = left_reg;
        stop_next  = stop_reg;
        ver_next   = ver_reg;
        grp_next   = grp_reg;
        pair_next  = pair_reg;
        auth_next  = auth_reg;
        dcip_next  = dcip_reg;
        dauth_next = dauth_reg;

        if (pos_reg == '0)
        begin
            dcip_next  = in_dcip_reg;
            dauth_next = in_dauth_reg;
        end

        if (!stop_reg)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg >= 8'd1)
                    begin
                        phase_next = PH_GROUP;
                    end
                end
                PH_GROUP:
                begin
                    if (pos_reg < 8'd5)
                    begin
                        suite_next = {suite_reg[15:0], in_byte_reg};
                        if (pos_reg == 8'd4)
                        begin
                            ver_next = rsnp_pkg::oui_version(suite_next);
                        end
                    end
                    else
                    begin
                        if (rsnp_pkg::oui_known(suite_reg))
                        begin
                            grp_next = grp_reg | rsnp_pkg::cipher_bits(in_byte_reg);
                        end
                        phase_next = PH_PCNT_LO;
                    end
                end
                PH_PCNT_LO:
                begin
                    cnt_next   = in_byte_reg;
                    phase_next = PH_PCNT_HI;
                end
                PH_ACNT_LO:
                begin
                    cnt_next   = in_byte_reg;
                    phase_next = PH_ACNT_HI;
                end
                PH_PCNT_HI:
                begin
                    if (too_long)
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        left_next  = cnt_reg[rsnp_pkg::LEFT_W-1:0];
                        phase_next = (cnt_reg == '0) ? PH_ACNT_LO : PH_PLIST;
                    end
                end
                PH_ACNT_HI:
                begin
                    if (too_long || cnt_reg == '0)
                    begin
                        stop_next = 1'b1;
                    end
                    else
                    begin
                        left_next  = cnt_reg[rsnp_pkg::LEFT_W-1:0];
                        phase_next = PH_ALIST;
                    end
                end
                PH_PLIST, PH_ALIST:
                begin
                    if (offset != 2'd3)
                    begin
                        suite_next = {suite_reg[15:0], in_byte_reg};
                    end
                    else
                    begin
                        if (rsnp_pkg::oui_known(suite_reg))
                        begin
                            if (akm)
                            begin
                                auth_next = auth_reg | rsnp_pkg::akm_bits(in_byte_reg);
                            end
                            else
                            begin
                                pair_next = pair_reg | rsnp_pkg::cipher_bits(in_byte_reg);
                            end
                        end
                        left_next = left_reg - 1'b1;
                        if (left_next == '0)
                        begin
                            if (akm)
                            begin
                                stop_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_ACNT_LO;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase
        end

        // Defaults fill in whatever the element left out, unless the parse has stopped.
        fin_ver  = ver_next;
        fin_grp  = grp_next;
        fin_pair = pair_next;
        fin_auth = auth_next;
        if (!stop_next)
        begin
            if (phase_next == PH_HEADER || phase_next == PH_GROUP)
            begin
                fin_grp  = grp_next | dcip_next;
                fin_pair = pair_next | dcip_next;
                fin_auth = auth_next | dauth_next;
            end
            else if (phase_next == PH_PCNT_LO || phase_next == PH_PCNT_HI)
            begin
                fin_pair = pair_next | dcip_next;
                fin_auth = auth_next | dauth_next;
            end
            else if (phase_next == PH_ACNT_LO || phase_next == PH_ACNT_HI)
            begin
                fin_auth = auth_next | dauth_next;
            end
        end

        pos_next = pos_reg + 8'd1;
        if (is_last)
        begin
            pos_next   = '0;
            phase_next = PH_HEADER;
            suite_next = '0;
            cnt_next   = '0;
            left_next  = '0;
            stop_next  = 1'b0;
            ver_next   = '0;
            grp_next   = '0;
            pair_next  = '0;
            auth_next  = '0;
            dcip_next  = '0;
            dauth_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            pos_reg       <= '0;
            phase_reg     <= PH_HEADER;
            suite_reg     <= '0;
            cnt_reg       <= '0;
            left_reg      <= '0;
            stop_reg      <= 1'b0;
            ver_reg       <= '0;
            grp_reg       <= '0;
            pair_reg      <= '0;
            auth_reg      <= '0;
            dcip_reg      <= '0;
            dauth_reg     <= '0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                pos_reg   <= pos_next;
                phase_reg <= phase_next;
                suite_reg <= suite_next;
                cnt_reg   <= cnt_next;
                left_reg  <= left_next;
                stop_reg  <= stop_next;
                ver_reg   <= ver_next;
                grp_reg   <= grp_next;
                pair_reg  <= pair_next;
                auth_reg  <= auth_next;
                dcip_reg  <= dcip_next;
                dauth_reg <= dauth_next;
            end

            if (advance && is_last)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg  <= s_axis_tdata[7:0];
            in_len_reg   <= s_axis_tdata[15:8];
            in_dcip_reg  <= s_axis_tdata[23:16];
            in_dauth_reg <= s_axis_tdata[31:24];
        end
        if (advance && is_last)
        begin
            res_ver_reg  <= fin_ver;
            res_grp_reg  <= fin_grp;
            res_pair_reg <= fin_pair;
            res_auth_reg <= fin_auth;
        end
    end

    assign m_axis_tvalid = res_valid_reg;
    assign m_axis_tdata  = {6'd0, res_auth_reg, res_pair_reg, res_grp_reg, res_ver_reg};

    // A running suite list always has at least one suite outstanding.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!stop_reg && (phase_reg == PH_PLIST || phase_reg == PH_ALIST)) |-> (left_reg != '0))
        else $error("suite list running with no suites left");

    // Closing an element returns the parser to the header position.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && is_last) |=> (pos_reg == '0 && phase_reg == PH_HEADER && !stop_reg))
        else $error("parser not rewound after closing byte");

    // The version accumulator only ever holds a known code.
    assert property (@(posedge clk) disable iff (!rst_n)
        (ver_reg == rsnp_pkg::VER_NONE || ver_reg == rsnp_pkg::VER_WPA ||
         ver_reg == rsnp_pkg::VER_RSN))
        else $error("illegal version code");

    // A result beat is produced only from a closing byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(advance && is_last))
        else $error("result beat without closing byte");

endmodule
